/* src/mfq_pkg.sv */
// Shared types, constants and helpers for the multilevel feedback queue scheduler.
`default_nettype none

package mfq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_Q       = 4;
  localparam int QSEL_W      = 2;
  localparam int MEM_DEPTH   = NUM_Q * QUEUE_DEPTH;
  localparam int ADDR_W      = QSEL_W + PTR_W;

  // Field widths
  localparam int PID_W   = 16;
  localparam int LVL_W   = 2;
  localparam int QNT_W   = 8;
  localparam int ENTRY_W = LVL_W + PID_W;

  // Reset values of the quantum registers
  localparam logic [QNT_W-1:0] DELTA1 = 8'd1;
  localparam logic [QNT_W-1:0] DELTA2 = 8'd2;
  localparam logic [QNT_W-1:0] DELTA3 = 8'd4;

  // Queue selects; slot 0 is the I/O wait FIFO, 1..3 are the levels
  localparam logic [QSEL_W-1:0] Q_IO = 2'd0;
  localparam logic [QSEL_W-1:0] Q_L1 = 2'd1;
  localparam logic [QSEL_W-1:0] Q_L2 = 2'd2;
  localparam logic [QSEL_W-1:0] Q_L3 = 2'd3;

  // Priority levels
  localparam logic [LVL_W-1:0] LVL_NONE = 2'd0;
  localparam logic [LVL_W-1:0] LVL_1    = 2'd1;
  localparam logic [LVL_W-1:0] LVL_2    = 2'd2;
  localparam logic [LVL_W-1:0] LVL_3    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_QUANTUM1 = 2'd0;
  localparam logic [1:0] CFG_QUANTUM2 = 2'd1;
  localparam logic [1:0] CFG_QUANTUM3 = 2'd2;

  typedef enum logic [1:0] {
    REQ_ADMIT    = 2'd0,
    REQ_DISPATCH = 2'd1,
    REQ_REPORT   = 2'd2,
    REQ_IO_DONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    OUT_FINISHED = 2'd0,
    OUT_QUANTUM  = 2'd1,
    OUT_BLOCKED  = 2'd2,
    OUT_INVALID  = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    STS_DISPATCHED = 3'd0,
    STS_DONE       = 3'd1,
    STS_IDLE       = 3'd2,
    STS_DROPPED    = 3'd3,
    STS_NONE       = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic [QNT_W-1:0] q3;
    logic [QNT_W-1:0] q2;
    logic [QNT_W-1:0] q1;
  } quanta_t;

  typedef struct packed {
    req_t             req_type;
    logic [PID_W-1:0] process_id;
    outcome_t         outcome;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [PID_W-1:0] process_id_res;
    logic [LVL_W-1:0] level;
    logic [QNT_W-1:0] quantum;
  } out_item_t;

  // Circular pointer advance, works for any depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

/* src/mfq_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module mfq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 18,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/mfq_ctrl.sv */
// Scheduler sequencer: queue pointers, active process, memory access and result register.
`default_nettype none

module mfq_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mfq_pkg::quanta_t         quanta,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire mfq_pkg::in_item_t        in_item,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      mfq_pkg::out_item_t       out_item,
  output      logic                     mem_wr_en,
  output      logic [mfq_pkg::ADDR_W-1:0]  mem_wr_addr,
  output      logic [mfq_pkg::ENTRY_W-1:0] mem_wr_data,
  output      logic                     mem_rd_en,
  output      logic [mfq_pkg::ADDR_W-1:0]  mem_rd_addr,
  input  wire logic [mfq_pkg::ENTRY_W-1:0] mem_rd_data
);
  import mfq_pkg::*;

  state_t state, state_next;

  logic [PTR_W-1:0] head_ptr [NUM_Q];
  logic [PTR_W-1:0] tail_ptr [NUM_Q];
  logic [CNT_W-1:0] qcount   [NUM_Q];
  logic [NUM_Q-1:0] q_full;
  logic [NUM_Q-1:0] q_empty;

  logic [PID_W-1:0] active_pid;
  logic [LVL_W-1:0] active_level;
  logic             active_valid;
  logic [LVL_W-1:0] pend_lvl, pend_lvl_next;

  logic              accept;
  logic              push_en;
  logic [QSEL_W-1:0] push_q;
  logic [ENTRY_W-1:0] push_data;
  logic              pop_en;
  logic [QSEL_W-1:0] pop_q;
  logic              act_clr, act_set;
  logic              res_load;
  out_item_t         res;

  logic [LVL_W-1:0] sel_lvl;
  logic [LVL_W-1:0] cur_lvl;
  logic [LVL_W-1:0] down_lvl;
  logic [PID_W-1:0] rd_pid;
  logic [LVL_W-1:0] rd_lvl;
  logic [LVL_W-1:0] up_lvl;
  logic [QNT_W-1:0] pend_quantum;

  always_comb begin
    for (int k = 0; k < NUM_Q; k++) begin
      q_full[k]  = (qcount[k] == CNT_W'(QUEUE_DEPTH));
      q_empty[k] = (qcount[k] == '0);
    end
  end

  // highest non-empty level
  always_comb begin
    priority if (!q_empty[Q_L1]) begin
      sel_lvl = LVL_1;
    end else if (!q_empty[Q_L2]) begin
      sel_lvl = LVL_2;
    end else if (!q_empty[Q_L3]) begin
      sel_lvl = LVL_3;
    end else begin
      sel_lvl = LVL_NONE;
    end
  end

  assign cur_lvl  = (active_level == LVL_NONE) ? LVL_1 : active_level;
  assign down_lvl = (cur_lvl == LVL_1) ? LVL_2 : LVL_3;
  assign rd_pid   = mem_rd_data[PID_W-1:0];
  assign rd_lvl   = mem_rd_data[ENTRY_W-1 -: LVL_W];
  assign up_lvl   = (rd_lvl == LVL_3) ? LVL_2 : LVL_1;

  always_comb begin
    unique case (pend_lvl)
      LVL_1:   pend_quantum = quanta.q1;
      LVL_2:   pend_quantum = quanta.q2;
      default: pend_quantum = quanta.q3;
    endcase
  end

  always_comb begin
    state_next    = state;
    pend_lvl_next = pend_lvl;
    in_ready      = (state == S_IDLE) && (!out_valid || out_ready);
    accept        = in_valid && in_ready;
    push_en       = 1'b0;
    push_q        = Q_L1;
    push_data     = '0;
    pop_en        = 1'b0;
    pop_q         = Q_IO;
    act_clr       = 1'b0;
    act_set       = 1'b0;
    res_load      = 1'b0;
    res           = '0;
    res.status    = STS_NONE;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item.req_type)
            REQ_ADMIT: begin
              push_en            = 1'b1;
              push_q             = Q_L1;
              push_data          = {LVL_1, in_item.process_id};
              res_load           = 1'b1;
              res.status         = q_full[Q_L1] ? STS_DROPPED : STS_DONE;
              res.process_id_res = in_item.process_id;
              res.level          = LVL_1;
            end
            REQ_DISPATCH: begin
              if (sel_lvl == LVL_NONE) begin
                res_load   = 1'b1;
                res.status = STS_IDLE;
              end else begin
                pop_en        = 1'b1;
                pop_q         = sel_lvl;
                pend_lvl_next = sel_lvl;
                state_next    = S_READ;
              end
            end
            REQ_REPORT: begin
              res_load = 1'b1;
              if (!active_valid || in_item.outcome == OUT_INVALID) begin
                res.status = STS_NONE;
              end else begin
                act_clr            = 1'b1;
                res.process_id_res = active_pid;
                case (in_item.outcome)
                  OUT_QUANTUM: begin
                    push_en    = 1'b1;
                    push_q     = down_lvl;
                    push_data  = {down_lvl, active_pid};
                    res.status = q_full[down_lvl] ? STS_DROPPED : STS_DONE;
                    res.level  = down_lvl;
                  end
                  OUT_BLOCKED: begin
                    push_en    = 1'b1;
                    push_q     = Q_IO;
                    push_data  = {cur_lvl, active_pid};
                    res.status = q_full[Q_IO] ? STS_DROPPED : STS_DONE;
                    res.level  = cur_lvl;
                  end
                  default: begin
                    res.status = STS_DONE;
                    res.level  = cur_lvl;
                  end
                endcase
              end
            end
            REQ_IO_DONE: begin
              if (q_empty[Q_IO]) begin
                res_load   = 1'b1;
                res.status = STS_NONE;
              end else begin
                pop_en        = 1'b1;
                pop_q         = Q_IO;
                pend_lvl_next = LVL_NONE;
                state_next    = S_READ;
              end
            end
          endcase
        end
      end
      S_READ: begin
        state_next         = S_IDLE;
        res_load           = 1'b1;
        res.process_id_res = rd_pid;
        if (pend_lvl != LVL_NONE) begin
          // dispatch: head entry becomes the active process
          act_set     = 1'b1;
          res.status  = STS_DISPATCHED;
          res.level   = pend_lvl;
          res.quantum = pend_quantum;
        end else begin
          // I/O completion: promote one level, no higher than level 1
          push_en    = 1'b1;
          push_q     = up_lvl;
          push_data  = {up_lvl, rd_pid};
          res.status = q_full[up_lvl] ? STS_DROPPED : STS_DONE;
          res.level  = up_lvl;
        end
      end
    endcase
  end

  assign mem_wr_en   = push_en && !q_full[push_q];
  assign mem_wr_addr = {push_q, tail_ptr[push_q]};
  assign mem_wr_data = push_data;
  assign mem_rd_en   = pop_en;
  assign mem_rd_addr = {pop_q, head_ptr[pop_q]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_Q; k++) begin
        head_ptr[k] <= '0;
        tail_ptr[k] <= '0;
        qcount[k]   <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_Q; k++) begin
        if (pop_en && pop_q == QSEL_W'(k)) begin
          head_ptr[k] <= ptr_inc(head_ptr[k]);
          qcount[k]   <= qcount[k] - CNT_W'(1);
        end else if (mem_wr_en && push_q == QSEL_W'(k)) begin
          tail_ptr[k] <= ptr_inc(tail_ptr[k]);
          qcount[k]   <= qcount[k] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_valid <= 1'b0;
      active_pid   <= '0;
      active_level <= LVL_NONE;
      pend_lvl     <= LVL_NONE;
    end else begin
      pend_lvl <= pend_lvl_next;
      if (act_set) begin
        active_valid <= 1'b1;
        active_pid   <= rd_pid;
        active_level <= pend_lvl;
      end else if (act_clr) begin
        active_valid <= 1'b0;
        active_pid   <= '0;
        active_level <= LVL_NONE;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item <= res;
    end
  end

  // ---------------------------------------------------------------- checks
  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> out_valid)
    else $error("memory read did not produce a result");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken while result stalled");

  a_dispatch_sets_active: assert property (@(posedge clk) disable iff (rst)
    (res_load && res.status == STS_DISPATCHED) |=> active_valid)
    else $error("dispatch left no active process");

  for (genvar g = 0; g < NUM_Q; g++) begin : g_chk
    a_empty_ptrs_meet: assert property (@(posedge clk) disable iff (rst)
      (qcount[g] == '0) |-> (head_ptr[g] == tail_ptr[g]))
      else $error("empty queue with head and tail apart");
  end

endmodule

`default_nettype wire

/* src/multilevel_feedback_queue_scheduler_top.sv */
// Top level of the three-level feedback queue scheduler.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the request kind
//   (admit, dispatch, report outcome, I/O complete); s_tdata carries the
//   process id and the outcome. Each request yields exactly one result on the
//   m_ stream: m_tuser carries the status, m_tdata the id, level and quantum.
//   Quantum registers for levels 1..3 are written through cfg_we/cfg_index/cfg_data; the user
//   must write them only while the block is idle, which it does not enforce; index 3 is ignored.
// Sequencing:
//   Admit, report, and a dispatch or I/O complete that finds nothing to pop
//   load the result register when the request is taken. A dispatch or I/O
//   complete that pops first reads the queue head from the shared RAM into
//   its registered read data, then loads the result register. One request is
//   in flight at a time: a popping request is answered before the next is taken.
// Reset:
//   rst synchronously clears pointers, counts, the active process and the result
//   valid flag; quanta return to 1, 2, 4. Queue RAM contents are not cleared.
// Stall:
//   A result waits in the output register while m_tready is low; a new
//   request is taken in the cycle that result leaves, never earlier.
`default_nettype none

module multilevel_feedback_queue_scheduler_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,   // [15:0] process_id, [17:16] outcome, rest zero
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  // result channel
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // [15:0] process_id_res, [17:16] level, [25:18] quantum
  output      logic [2:0]  m_tuser,   // [2:0] status
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import mfq_pkg::*;

  quanta_t   quanta;
  in_item_t  in_item;
  out_item_t out_item;

  logic               mem_wr_en;
  logic [ADDR_W-1:0]  mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;
  logic               mem_rd_en;
  logic [ADDR_W-1:0]  mem_rd_addr;
  logic [ENTRY_W-1:0] mem_rd_data;

  // quantum registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quanta.q1 <= DELTA1;
      quanta.q2 <= DELTA2;
      quanta.q3 <= DELTA3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUANTUM1: quanta.q1 <= cfg_data;
        CFG_QUANTUM2: quanta.q2 <= cfg_data;
        CFG_QUANTUM3: quanta.q3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack request
  assign in_item.req_type   = req_t'(s_tuser);
  assign in_item.process_id = s_tdata[PID_W-1:0];
  assign in_item.outcome    = outcome_t'(s_tdata[PID_W+1:PID_W]);

  // pack result
  assign m_tuser = out_item.status;
  assign m_tdata = {6'd0, out_item.quantum, out_item.level, out_item.process_id_res};

  mfq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .quanta      (quanta),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (in_item),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_item    (out_item),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // all four queues share one RAM, addressed {queue, slot}
  mfq_ram #(
    .DEPTH (MEM_DEPTH),
    .WIDTH (ENTRY_W),
    .AW    (ADDR_W)
  ) u_qram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

/* tb/multilevel_feedback_queue_scheduler_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the multilevel feedback queue scheduler top level.
module multilevel_feedback_queue_scheduler_top_test;
  import mfq_pkg::*;

  // Index 3 of the config port maps to no register; writes there must be ignored
  localparam logic [1:0] CFG_SPARE      = 2'd3;
  // Cycles with no handshake on either stream before the run is declared hung
  localparam int         WATCHDOG_LIMIT = 5000;
  // Settle time after the last reply
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         MAX_PRINTS     = 40;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;   // [15:0] process_id, [17:16] outcome, rest zero
  logic [1:0]  s_tuser   = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;          // [15:0] process_id_res, [17:16] level, [25:18] quantum
  logic [2:0]  m_tuser;          // [2:0] status
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;

  always #5 clk = ~clk;

  multilevel_feedback_queue_scheduler_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Scheduler shadow state: ready FIFOs per level, the I/O wait FIFO (entries
  // hold {level, pid}), the running process and the per-level time slices.
  // ---------------------------------------------------------------------------
  logic [PID_W-1:0]   lvl1_fifo[$];
  logic [PID_W-1:0]   lvl2_fifo[$];
  logic [PID_W-1:0]   lvl3_fifo[$];
  logic [ENTRY_W-1:0] io_fifo[$];
  logic [PID_W-1:0]   running_pid   = '0;
  logic [LVL_W-1:0]   running_level = LVL_NONE;
  logic               running_valid = 1'b0;
  logic [QNT_W-1:0]   granted_quantum [1:3];

  out_item_t expected_replies[$];   // replies owed by the DUT, oldest first
  int        error_count   = 0;
  int        stall_cycles  = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  function automatic int level_fill(input logic [LVL_W-1:0] lvl);
    case (lvl)
      LVL_1: return lvl1_fifo.size();
      LVL_2: return lvl2_fifo.size();
      default: return lvl3_fifo.size();
    endcase
  endfunction

  // Returns 0 when the level is full and the pid is lost
  function automatic bit push_level(input logic [LVL_W-1:0] lvl, input logic [PID_W-1:0] pid);
    if (level_fill(lvl) >= QUEUE_DEPTH) return 1'b0;
    case (lvl)
      LVL_1: lvl1_fifo.push_back(pid);
      LVL_2: lvl2_fifo.push_back(pid);
      default: lvl3_fifo.push_back(pid);
    endcase
    return 1'b1;
  endfunction

  function automatic logic [PID_W-1:0] pop_level(input logic [LVL_W-1:0] lvl);
    case (lvl)
      LVL_1: return lvl1_fifo.pop_front();
      LVL_2: return lvl2_fifo.pop_front();
      default: return lvl3_fifo.pop_front();
    endcase
  endfunction

  // Applies one request to the shadow state and returns the reply it owes
  function automatic out_item_t schedule_request(input in_item_t req);
    out_item_t          r;
    logic [LVL_W-1:0]   lvl;
    logic [LVL_W-1:0]   dest;
    logic [PID_W-1:0]   pid;
    logic [ENTRY_W-1:0] entry;
    bit                 ok;
    r.status         = STS_NONE;
    r.process_id_res = '0;
    r.level          = LVL_NONE;
    r.quantum        = '0;
    case (req.req_type)
      REQ_ADMIT: begin
        ok               = push_level(LVL_1, req.process_id);
        r.status         = ok ? STS_DONE : STS_DROPPED;
        r.process_id_res = req.process_id;
        r.level          = LVL_1;
      end
      REQ_DISPATCH: begin
        if (lvl1_fifo.size() != 0) lvl = LVL_1;
        else if (lvl2_fifo.size() != 0) lvl = LVL_2;
        else if (lvl3_fifo.size() != 0) lvl = LVL_3;
        else lvl = LVL_NONE;
        if (lvl == LVL_NONE) begin
          // nothing ready; a running process stays as it is
          r.status = STS_IDLE;
        end else begin
          // a process already running is overwritten and lost
          running_pid      = pop_level(lvl);
          running_level    = lvl;
          running_valid    = 1'b1;
          r.status         = STS_DISPATCHED;
          r.process_id_res = running_pid;
          r.level          = lvl;
          r.quantum        = granted_quantum[lvl];
        end
      end
      REQ_REPORT: begin
        // invalid outcome keeps the running process untouched
        if (running_valid && req.outcome != OUT_INVALID) begin
          pid              = running_pid;
          lvl              = running_level;
          running_valid    = 1'b0;
          running_pid      = '0;
          running_level    = LVL_NONE;
          r.process_id_res = pid;
          case (req.outcome)
            OUT_FINISHED: begin
              r.status = STS_DONE;
              r.level  = lvl;
            end
            OUT_QUANTUM: begin
              dest     = (lvl == LVL_1) ? LVL_2 : LVL_3;   // demote, floor at 3
              ok       = push_level(dest, pid);
              r.status = ok ? STS_DONE : STS_DROPPED;
              r.level  = dest;
            end
            default: begin
              ok = io_fifo.size() < QUEUE_DEPTH;
              if (ok) io_fifo.push_back({lvl, pid});
              r.status = ok ? STS_DONE : STS_DROPPED;
              r.level  = lvl;
            end
          endcase
        end
      end
      default: begin
        if (io_fifo.size() != 0) begin
          entry            = io_fifo.pop_front();
          pid              = entry[PID_W-1:0];
          lvl              = entry[ENTRY_W-1:PID_W];
          dest             = (lvl == LVL_3) ? LVL_2 : LVL_1;   // promote, ceiling at 1
          ok               = push_level(dest, pid);
          r.status         = ok ? STS_DONE : STS_DROPPED;
          r.process_id_res = pid;
          r.level          = dest;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    if (error_count < MAX_PRINTS)
      $display("ERROR %0t: %s got %0h expected %0h", $time, what, got_v, want_v);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. Drives at the falling edge, honors the sender idle rate,
  // and holds the request until the DUT takes it. The reply is predicted at
  // the accepting edge, so shadow state always matches what the DUT has taken.
  // ---------------------------------------------------------------------------
  task automatic send_request(input req_t kind, input logic [PID_W-1:0] pid,
                              input outcome_t oc);
    in_item_t req;
    req.req_type   = kind;
    req.process_id = pid;
    req.outcome    = oc;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, oc, pid};
    s_tuser  <= kind;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    expected_replies.push_back(schedule_request(req));
  endtask

  // Stops the request stream and waits until every owed reply is in
  task automatic wait_for_replies;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  // Quantum writes only go in while nothing is in flight
  task automatic write_quantum(input logic [1:0] idx, input logic [QNT_W-1:0] val);
    wait_for_replies();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_QUANTUM1: granted_quantum[1] = val;
      CFG_QUANTUM2: granted_quantum[2] = val;
      CFG_QUANTUM3: granted_quantum[3] = val;
      default: ;
    endcase
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Receiver: random backpressure, changed at the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Reply checker: sampled at the rising edge, compared field by field
  always @(posedge clk) begin : reply_check
    out_item_t got;
    out_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status         = status_t'(m_tuser);
      got.process_id_res = m_tdata[15:0];
      got.level          = m_tdata[17:16];
      got.quantum        = m_tdata[25:18];
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with no request pending", m_tdata, m_tuser);
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
        if (got.process_id_res !== want.process_id_res)
          report_mismatch("process_id_res", got.process_id_res, want.process_id_res);
        if (got.level !== want.level)
          report_mismatch("level", got.level, want.level);
        if (got.quantum !== want.quantum)
          report_mismatch("quantum", got.quantum, want.quantum);
      end
    end
  end

  // Watchdog: any handshake on either stream resets the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR %0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Dispatch, report and I/O complete requests against an empty scheduler
  task automatic test_empty_scheduler;
    send_request(REQ_DISPATCH, 16'h0000, OUT_FINISHED);
    send_request(REQ_REPORT,   16'h0000, OUT_FINISHED);
    send_request(REQ_REPORT,   16'hFFFF, OUT_INVALID);
    send_request(REQ_IO_DONE,  16'h0000, OUT_FINISHED);
  endtask

  // Walks one process through every level move; quanta set to 255 / 0 / 1
  task automatic test_level_moves;
    write_quantum(CFG_QUANTUM1, 8'hFF);
    write_quantum(CFG_QUANTUM2, 8'h00);
    write_quantum(CFG_QUANTUM3, 8'h01);
    write_quantum(CFG_SPARE,    8'hA5);   // no register behind it
    send_request(REQ_ADMIT,    16'h0000, OUT_FINISHED);
    send_request(REQ_ADMIT,    16'hFFFF, OUT_FINISHED);
    send_request(REQ_DISPATCH, 16'h0000, OUT_FINISHED);   // 0000 at level 1
    send_request(REQ_REPORT,   16'h0000, OUT_INVALID);    // ignored, stays running
    send_request(REQ_REPORT,   16'h0000, OUT_QUANTUM);    // 0000 down to level 2
    send_request(REQ_DISPATCH, 16'h0000, OUT_FINISHED);   // FFFF at level 1
    send_request(REQ_REPORT,   16'h0000, OUT_BLOCKED);
    send_request(REQ_IO_DONE,  16'h0000, OUT_FINISHED);   // level 1 stays 1
    send_request(REQ_DISPATCH, 16'h0000, OUT_FINISHED);   // FFFF again
    send_request(REQ_DISPATCH, 16'h0000, OUT_FINISHED);   // 0000 replaces it, FFFF lost
    send_request(REQ_REPORT,   16'h0000, OUT_QUANTUM);    // down to level 3
    send_request(REQ_DISPATCH, 16'h0000, OUT_FINISHED);
    send_request(REQ_REPORT,   16'h0000, OUT_QUANTUM);    // level 3 stays 3
    send_request(REQ_DISPATCH, 16'h0000, OUT_FINISHED);
    send_request(REQ_REPORT,   16'h0000, OUT_BLOCKED);
    send_request(REQ_IO_DONE,  16'h0000, OUT_FINISHED);   // level 3 up to 2
    send_request(REQ_DISPATCH, 16'h0000, OUT_FINISHED);
    send_request(REQ_REPORT,   16'h0000, OUT_BLOCKED);
    send_request(REQ_IO_DONE,  16'h0000, OUT_FINISHED);   // level 2 up to 1
    send_request(REQ_DISPATCH, 16'h0000, OUT_FINISHED);
    send_request(REQ_REPORT,   16'h0000, OUT_FINISHED);
  endtask

  // Fills every queue to the brim and pushes one more into each
  task automatic test_queue_overflow;
    int n;
    for (n = 0; n <= QUEUE_DEPTH; n++)
      send_request(REQ_ADMIT, 16'($urandom), OUT_FINISHED);   // last admit dropped
    for (n = 0; n < QUEUE_DEPTH; n++) begin
      send_request(REQ_DISPATCH, 16'($urandom), OUT_FINISHED);
      send_request(REQ_REPORT,   16'($urandom), OUT_QUANTUM);
    end
    // level 2 full: demotion from level 1 dropped
    send_request(REQ_ADMIT,    16'($urandom), OUT_FINISHED);
    send_request(REQ_DISPATCH, 16'($urandom), OUT_FINISHED);
    send_request(REQ_REPORT,   16'($urandom), OUT_QUANTUM);
    for (n = 0; n < QUEUE_DEPTH; n++) begin
      send_request(REQ_DISPATCH, 16'($urandom), OUT_FINISHED);
      send_request(REQ_REPORT,   16'($urandom), OUT_QUANTUM);
    end
    // level 3 full: demotion from level 2 dropped
    send_request(REQ_ADMIT,    16'($urandom), OUT_FINISHED);
    send_request(REQ_DISPATCH, 16'($urandom), OUT_FINISHED);
    send_request(REQ_REPORT,   16'($urandom), OUT_QUANTUM);
    send_request(REQ_DISPATCH, 16'($urandom), OUT_FINISHED);
    send_request(REQ_REPORT,   16'($urandom), OUT_QUANTUM);
    // I/O FIFO full of level 1 processes, then one more blocks
    for (n = 0; n < QUEUE_DEPTH; n++)
      send_request(REQ_ADMIT, 16'($urandom), OUT_FINISHED);
    for (n = 0; n <= QUEUE_DEPTH; n++) begin
      if (n == QUEUE_DEPTH) send_request(REQ_ADMIT, 16'($urandom), OUT_FINISHED);
      send_request(REQ_DISPATCH, 16'($urandom), OUT_FINISHED);
      send_request(REQ_REPORT,   16'($urandom), OUT_BLOCKED);
    end
    // level 1 full: I/O completions dropped
    for (n = 0; n < QUEUE_DEPTH; n++)
      send_request(REQ_ADMIT, 16'($urandom), OUT_FINISHED);
    send_request(REQ_IO_DONE, 16'($urandom), OUT_FINISHED);
    send_request(REQ_IO_DONE, 16'($urandom), OUT_FINISHED);
  endtask

  // Mostly well-formed traffic (reports follow dispatches), with stray
  // requests mixed in; admit bias swings so queues fill up and drain again.
  task automatic run_random_traffic(input int count);
    int n;
    int roll;
    int pick;
    int admit_weight;
    admit_weight = 45;
    for (n = 0; n < count; n++) begin
      if (n % 100 == 0) admit_weight = (admit_weight == 45) ? 15 : 45;
      if (n == count / 2) wait_for_replies();   // sender holds until all replies are in
      roll = $urandom_range(99);
      if (roll < 12) begin
        send_request(req_t'($urandom_range(3)), 16'($urandom), outcome_t'($urandom_range(3)));
      end else if (running_valid && roll < 60) begin
        send_request(REQ_REPORT, 16'($urandom), outcome_t'($urandom_range(2)));
      end else begin
        pick = $urandom_range(99);
        if (pick < admit_weight)
          send_request(REQ_ADMIT, 16'($urandom), outcome_t'($urandom_range(3)));
        else if (pick < admit_weight + 40)
          send_request(REQ_DISPATCH, 16'($urandom), outcome_t'($urandom_range(3)));
        else
          send_request(REQ_IO_DONE, 16'($urandom), outcome_t'($urandom_range(3)));
      end
    end
  endtask

  initial begin
    granted_quantum[1] = DELTA1;
    granted_quantum[2] = DELTA2;
    granted_quantum[3] = DELTA3;
    set_idling(20, 47);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_scheduler();
    test_level_moves();
    write_quantum(CFG_QUANTUM1, 8'd1);
    write_quantum(CFG_QUANTUM2, 8'd2);
    write_quantum(CFG_QUANTUM3, 8'd4);
    test_queue_overflow();

    write_quantum(CFG_QUANTUM1, 8'($urandom_range(255, 1)));
    write_quantum(CFG_QUANTUM2, 8'($urandom_range(255, 1)));
    write_quantum(CFG_QUANTUM3, 8'($urandom_range(255, 1)));
    run_random_traffic(600);

    set_idling(47, 20);
    write_quantum(CFG_QUANTUM1, 8'd1);
    write_quantum(CFG_QUANTUM2, 8'hFF);
    write_quantum(CFG_QUANTUM3, 8'h00);
    run_random_traffic(600);

    set_idling(0, 0);
    write_quantum(CFG_QUANTUM1, 8'($urandom_range(255, 1)));
    write_quantum(CFG_QUANTUM2, 8'($urandom_range(255, 1)));
    write_quantum(CFG_QUANTUM3, 8'($urandom_range(255, 1)));
    run_random_traffic(600);

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
